@@ sv/dttn_pkg.sv @@
package dttn_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned MantW  = 32;
  localparam int unsigned FracW  = 4;
  localparam int unsigned CountW = 9;

  localparam logic [CountW-1:0] MaxChars = 9'd256;
  localparam logic [FracW-1:0]  MaxFrac  = 4'd9;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChComma = 8'h2C;

  localparam logic [MantW-1:0] MantMax = {MantW{1'b1}};

  typedef enum logic [3:0] {
    PhBefore = 4'b0001,
    PhInt    = 4'b0010,
    PhFrac   = 4'b0100,
    PhDone   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [MantW-1:0] mantissa;
    logic [FracW-1:0] frac_digits;
    logic             saturated;
    logic             digit_seen;
  } result_t;

endpackage

@@ sv/dttn_parser.sv @@
module dttn_parser
  import dttn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_i,
  input  logic             eot_i,
  output result_t          res_o
);

  phase_e            phase_q, phase_d;
  logic [MantW-1:0]  acc_q, acc_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;

  logic             is_digit;
  logic             is_sep;
  logic [3:0]       digit;
  logic [MantW+3:0] times_ten;
  logic [MantW-1:0] push_val;
  logic             push_ovf;

  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_sep   = (char_i == ChDot) || (char_i == ChComma);
  assign digit    = 4'(char_i - ChZero);

  // acc * 10 + digit, built from two shifts; the top four bits flag overflow.
  assign times_ten = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + (MantW+4)'(digit);
  assign push_ovf  = ovf_q || (times_ten[MantW+3:MantW] != 4'd0);
  assign push_val  = push_ovf ? MantMax : times_ten[MantW-1:0];

  always_comb begin
    res_o.digit_seen  = (phase_q != PhBefore);
    res_o.mantissa    = res_o.digit_seen ? acc_q : '0;
    res_o.frac_digits = res_o.digit_seen ? frac_q : '0;
    res_o.saturated   = res_o.digit_seen ? ovf_q : 1'b0;
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (step_i) begin
      if (eot_i) begin
        phase_d = PhBefore;
        acc_d   = '0;
        frac_d  = '0;
        count_d = '0;
        ovf_d   = 1'b0;
      end else if (count_q < MaxChars) begin
        count_d = count_q + CountW'(1);
        case (phase_q)
          PhBefore: begin
            if (is_digit) begin
              acc_d   = MantW'(digit);
              phase_d = PhInt;
            end
          end
          PhInt: begin
            if (is_digit) begin
              acc_d = push_val;
              ovf_d = push_ovf;
            end else if (is_sep) begin
              phase_d = PhFrac;
            end else begin
              phase_d = PhDone;
            end
          end
          PhFrac: begin
            if (is_digit) begin
              if (frac_q < MaxFrac) begin
                acc_d  = push_val;
                ovf_d  = push_ovf;
                frac_d = frac_q + FracW'(1);
              end
            end else begin
              phase_d = PhDone;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhBefore;
      acc_q   <= '0;
      frac_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

@@ sv/dttn_out_buf.sv @@
module dttn_out_buf
  import dttn_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ sv/decimal_text_to_number.sv @@
// Pulls the first decimal number out of a byte stream and reports it as a
// 32-bit mantissa plus a count of fraction digits (value = mantissa / 10^count).
// One byte item is taken per clock: each item is registered, then decoded and
// folded into the parser state by a single times-ten add in the next cycle.
// An item with end_of_text set yields one result via the input register, then
// the output register, and returns the parser to its reset state. Input stalls
// only while a terminator waits on the output register, which holds until taken.
module decimal_text_to_number
  import dttn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] char_code_i,
  input  logic             end_of_text_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [MantW-1:0] mantissa_o,
  output logic [FracW-1:0] frac_digits_o,
  output logic             saturated_o,
  output logic             digit_seen_o
);

  logic             s1_valid_q, s1_valid_d;
  logic [CharW-1:0] s1_char_q;
  logic             s1_eot_q;
  logic             s1_take;
  logic             out_free;
  logic             in_fire;
  result_t          parse_res;
  result_t          out_res;

  // A plain byte never waits; a terminator needs room in the output register.
  assign s1_take    = s1_valid_q && (!s1_eot_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_take;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_take) begin
      s1_valid_d = 1'b0;
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= char_code_i;
      s1_eot_q  <= end_of_text_i;
    end
  end

  dttn_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_take),
    .char_i (s1_char_q),
    .eot_i  (s1_eot_q),
    .res_o  (parse_res)
  );

  dttn_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_take && s1_eot_q),
    .res_i   (parse_res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign mantissa_o    = out_res.mantissa;
  assign frac_digits_o = out_res.frac_digits;
  assign saturated_o   = out_res.saturated;
  assign digit_seen_o  = out_res.digit_seen;

  a_stall_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i)
  ) else $error("input stalled while output register could accept");

  a_no_digit_is_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !digit_seen_o) |->
      (mantissa_o == '0 && frac_digits_o == '0 && !saturated_o)
  ) else $error("digitless result carries a nonzero field");

  a_frac_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frac_digits_o <= MaxFrac)
  ) else $error("fraction digit count above limit");

  a_sat_clamped: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (mantissa_o == MantMax)
  ) else $error("saturated result is not clamped");

endmodule

@@ tb/decimal_text_to_number_test.sv @@
`timescale 1ns / 100ps

module decimal_text_to_number_test;
  import dttn_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 300;

  // Tracks the parser state for each accepted byte and keeps the numbers that the
  // terminator items should produce, oldest first.
  class number_checker;
    phase_e           parse_phase;
    logic [MantW-1:0] mant_acc;
    logic [FracW-1:0] frac_kept;
    logic [CountW-1:0] bytes_seen;
    bit               clamped;
    result_t          expected_numbers[$];
    int               failures;

    function new();
      failures = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      parse_phase = PhBefore;
      mant_acc    = '0;
      frac_kept   = '0;
      bytes_seen  = '0;
      clamped     = 1'b0;
    endfunction

    function void add_digit(logic [3:0] d);
      logic [63:0] wide;
      if (clamped) begin
        mant_acc = MantMax;
        return;
      end
      wide = {32'd0, mant_acc} * 64'd10 + {60'd0, d};
      if (wide[63:32] != 32'd0) begin
        mant_acc = MantMax;
        clamped  = 1'b1;
      end else begin
        mant_acc = wide[31:0];
      end
    endfunction

    function void note_byte(logic [CharW-1:0] c, logic eot);
      result_t          num;
      logic [CharW-1:0] offset;
      bit               is_digit;
      bit               is_sep;
      if (eot) begin
        num = '0;
        if (parse_phase != PhBefore) begin
          num.mantissa    = mant_acc;
          num.frac_digits = frac_kept;
          num.saturated   = clamped;
          num.digit_seen  = 1'b1;
        end
        expected_numbers.push_back(num);
        clear_parse();
        return;
      end
      // Bytes past the length limit are dropped without touching the parse.
      if (bytes_seen >= MaxChars) return;
      bytes_seen++;
      offset   = c - ChZero;
      is_digit = (c >= ChZero) && (c <= ChNine);
      is_sep   = (c == ChDot) || (c == ChComma);
      case (parse_phase)
        PhBefore: begin
          if (is_digit) begin
            mant_acc    = {28'd0, offset[3:0]};
            parse_phase = PhInt;
          end
        end
        PhInt: begin
          if (is_digit) add_digit(offset[3:0]);
          else if (is_sep) parse_phase = PhFrac;
          else parse_phase = PhDone;
        end
        PhFrac: begin
          if (is_digit) begin
            if (frac_kept < MaxFrac) begin
              add_digit(offset[3:0]);
              frac_kept++;
            end
          end else begin
            parse_phase = PhDone;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_number(logic [MantW-1:0] mant, logic [FracW-1:0] frac,
                               logic sat, logic seen);
      result_t want;
      if (expected_numbers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: mant=%0d frac=%0d sat=%0b seen=%0b",
                   mant, frac, sat, seen);
        return;
      end
      want = expected_numbers.pop_front();
      if (mant !== want.mantissa || frac !== want.frac_digits ||
          sat !== want.saturated || seen !== want.digit_seen) begin
        failures++;
        if (failures <= 10) begin
          $write("mismatch: expected mant=%0d frac=%0d sat=%0b seen=%0b, ",
                 want.mantissa, want.frac_digits, want.saturated, want.digit_seen);
          $display("got mant=%0d frac=%0d sat=%0b seen=%0b",
                   mant, frac, sat, seen);
        end
      end
    endfunction

    function int pending();
      return expected_numbers.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [CharW-1:0] char_code_i;
  logic             end_of_text_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [MantW-1:0] mantissa_o;
  logic [FracW-1:0] frac_digits_o;
  logic             saturated_o;
  logic             digit_seen_o;

  number_checker board;
  int            send_idle;
  int            recv_idle;
  int            bytes_sent;
  int unsigned   cycles;
  logic          stall_req;
  bit            stall_done;
  int            stall_left;

  decimal_text_to_number DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mantissa_o    (mantissa_o),
    .frac_digits_o (frac_digits_o),
    .saturated_o   (saturated_o),
    .digit_seen_o  (digit_seen_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check whatever is taken at this edge, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_number(mantissa_o, frac_digits_o, saturated_o, digit_seen_o);
    if (stall_req && !stall_done) begin
      stall_left = HoldCycles;
      stall_done = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_byte(logic [CharW-1:0] c, logic eot);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_code_i   <= c;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_byte(c, eot);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    send_byte(CharW'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [CharW-1:0] random_nondigit();
    logic [CharW-1:0] b;
    do b = CharW'($urandom_range(255));
    while (b >= ChZero && b <= ChNine);
    return b;
  endfunction

  function automatic logic [CharW-1:0] random_digit(bit nines);
    return nines ? ChNine : ChZero + CharW'($urandom_range(9));
  endfunction

  // Mostly well-formed numbers with random surroundings; the rest is noise,
  // runs of digits and separators, or empty strings.
  task automatic send_random_string();
    int kind;
    int n;
    int pick;
    bit nines;
    kind  = $urandom_range(9);
    nines = ($urandom_range(3) == 0);
    if (kind < 7) begin
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) send_byte(random_nondigit(), 1'b0);
      n = ($urandom_range(3) == 0) ? $urandom_range(14, 8) : $urandom_range(6, 1);
      for (int i = 0; i < n; i++) send_byte(random_digit(nines), 1'b0);
      if ($urandom_range(3) != 0) begin
        send_byte($urandom_range(1) ? ChDot : ChComma, 1'b0);
        n = $urandom_range(12);
        for (int i = 0; i < n; i++) send_byte(random_digit(nines), 1'b0);
      end
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) send_byte(CharW'($urandom_range(255)), 1'b0);
    end else if (kind == 7) begin
      n = $urandom_range(12);
      for (int i = 0; i < n; i++) send_byte(CharW'($urandom_range(255)), 1'b0);
    end else if (kind == 8) begin
      n = $urandom_range(10, 1);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(11);
        if (pick < 10) send_byte(random_digit(1'b0), 1'b0);
        else send_byte((pick == 10) ? ChDot : ChComma, 1'b0);
      end
    end
    send_byte(CharW'($urandom_range(255)), 1'b1);
  endtask

  // A number that starts just before the length limit and runs past it.
  task automatic send_long_string();
    int lead;
    int total;
    lead  = $urandom_range(250, 240);
    total = int'(MaxChars) + $urandom_range(15, 1);
    for (int i = 0; i < lead; i++) send_byte(random_nondigit(), 1'b0);
    for (int i = lead; i < total; i++)
      send_byte((i == lead + 3) ? ChDot : random_digit(1'b0), 1'b0);
    send_byte(CharW'($urandom_range(255)), 1'b1);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    char_code_i   = '0;
    end_of_text_i = 1'b0;
    out_ready_i   = 1'b0;
    stall_req     = 1'b0;
    stall_done    = 1'b0;
    stall_left    = 0;
    cycles        = 0;
    bytes_sent    = 0;
    send_idle     = 32;
    recv_idle     = 79;
    board         = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("");
    send_text("0");
    send_text("x9");
    send_text("1.5");
    send_text("2,7.");
    send_text("4294967296");
    while (bytes_sent < 150) send_random_string();
    send_long_string();
    wait_drain();

    send_idle <= 79;
    recv_idle <= 32;
    while (bytes_sent < 600) send_random_string();
    wait_drain();

    // No idling here, but the result side holds off for a while to back up the input.
    send_idle <= 0;
    recv_idle <= 0;
    stall_req <= 1'b1;
    @(posedge clk_i);
    while (bytes_sent < 750) send_random_string();
    send_long_string();
    wait_drain();

    repeat (10) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
